>>> design/pkt_pkg.sv
// ----------------------------------------------------------------------------
// pkt_pkg
// Types and codes shared by the pressed key table controller and datapath.
// ----------------------------------------------------------------------------
package pkt_pkg;

  localparam int CODE_W = 9;
  localparam int ST_W   = 2;

  // command codes
  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // key action codes
  localparam logic [1:0] ACT_RELEASE = 2'd0;
  localparam logic [1:0] ACT_PRESS   = 2'd1;

  // key states
  localparam logic [ST_W-1:0] ST_UP         = 2'd0;
  localparam logic [ST_W-1:0] ST_UP_FIRST   = 2'd1;
  localparam logic [ST_W-1:0] ST_DOWN       = 2'd2;
  localparam logic [ST_W-1:0] ST_DOWN_FIRST = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ST_W-1:0]   st;
  } entry_t;

  typedef enum logic [2:0] {
    IDLE,
    DISPATCH,
    S_CMP,
    T_CHECK,
    T_LOAD,
    T_EXAM,
    R_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RD_I,
    RD_INEXT,
    RD_NLAST,
    RD_INDEX
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_EVENT,
    WR_APPEND,
    WR_KEEP
  } wr_kind_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_PLAIN,
    RES_FOUND,
    RES_ENTRY
  } res_kind_t;

  typedef struct packed {
    logic      load_in;
    logic      rd_en;
    rd_sel_t   rd_sel;
    wr_kind_t  wr_kind;
    logic      i_inc;
    logic      n_dec;
    logic      cur_load;
    logic      cnt_inc;
    logic      cnt_from_n;
    res_kind_t res_kind;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       negative;
    logic       cnt_zero;
    logic       append_ok;
    logic       idx_ok;
    logic       match;
    logic       last;
    logic       tick_done;
    logic       keep;
    logic       move_ok;
  } stat_t;

endpackage

>>> design/pkt_ram.sv
// ----------------------------------------------------------------------------
// pkt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/pkt_ctrl.sv
// ----------------------------------------------------------------------------
// pkt_ctrl
// Sequencer for key events, frame ticks, queries and index reads.
// ----------------------------------------------------------------------------
module pkt_ctrl
  import pkt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (start) state_next = DISPATCH;
      end
      DISPATCH: begin
        case (stat.cmd)
          CMD_EVENT, CMD_QUERY: begin
            if (stat.negative || stat.cnt_zero) state_next = IDLE;
            else state_next = S_CMP;
          end
          CMD_TICK: state_next = T_CHECK;
          CMD_READ: begin
            if (stat.idx_ok) state_next = R_WAIT;
            else state_next = IDLE;
          end
          default: state_next = IDLE;
        endcase
      end
      S_CMP: begin
        if (stat.match || stat.last) state_next = IDLE;
      end
      T_CHECK: begin
        if (stat.tick_done) state_next = IDLE;
        else state_next = T_LOAD;
      end
      T_LOAD: state_next = T_EXAM;
      T_EXAM: begin
        if (!stat.keep && stat.move_ok) state_next = T_LOAD;
        else state_next = T_CHECK;
      end
      R_WAIT: state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.rd_sel   = RD_I;
    ctrl.wr_kind  = WR_NONE;
    ctrl.res_kind = RES_NONE;
    case (state)
      IDLE: begin
        ctrl.load_in = start;
      end
      DISPATCH: begin
        case (stat.cmd)
          CMD_EVENT, CMD_QUERY: begin
            if (stat.negative) begin
              ctrl.res_kind = RES_PLAIN;
            end else if (stat.cnt_zero) begin
              // empty table: a miss right away
              if (stat.cmd == CMD_EVENT && stat.append_ok) begin
                ctrl.wr_kind = WR_APPEND;
                ctrl.cnt_inc = 1'b1;
              end
              ctrl.res_kind = RES_PLAIN;
            end else begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = RD_I;
            end
          end
          CMD_READ: begin
            if (stat.idx_ok) begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = RD_INDEX;
            end else begin
              ctrl.res_kind = RES_PLAIN;
            end
          end
          default: ;
        endcase
      end
      S_CMP: begin
        if (stat.match) begin
          if (stat.cmd == CMD_EVENT) begin
            ctrl.wr_kind  = WR_EVENT;
            ctrl.res_kind = RES_PLAIN;
          end else begin
            ctrl.res_kind = RES_FOUND;
          end
        end else if (stat.last) begin
          if (stat.cmd == CMD_EVENT && stat.append_ok) begin
            ctrl.wr_kind = WR_APPEND;
            ctrl.cnt_inc = 1'b1;
          end
          ctrl.res_kind = RES_PLAIN;
        end else begin
          // fetch the next entry while advancing
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_INEXT;
          ctrl.i_inc  = 1'b1;
        end
      end
      T_CHECK: begin
        if (stat.tick_done) begin
          ctrl.cnt_from_n = 1'b1;
          ctrl.res_kind   = RES_PLAIN;
        end else begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_I;
        end
      end
      T_LOAD: begin
        ctrl.cur_load = 1'b1;
      end
      T_EXAM: begin
        if (stat.keep) begin
          ctrl.wr_kind = WR_KEEP;
          ctrl.i_inc   = 1'b1;
        end else begin
          // drop the entry: pull the last one into the hole
          ctrl.n_dec = 1'b1;
          if (stat.move_ok) begin
            ctrl.rd_en  = 1'b1;
            ctrl.rd_sel = RD_NLAST;
          end
        end
      end
      R_WAIT: begin
        ctrl.res_kind = RES_ENTRY;
      end
      default: ;
    endcase
  end

endmodule

>>> design/pkt_dp.sv
// ----------------------------------------------------------------------------
// pkt_dp
// Datapath: entry RAM, count, walk pointers and result registers.
// ----------------------------------------------------------------------------
module pkt_dp
  import pkt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        command,
  input  logic signed [9:0] key_code,
  input  logic [1:0]        key_action,
  input  logic [3:0]        entry_index,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  output logic              done,
  output logic              key_found,
  output logic              key_held,
  output logic              key_went_down,
  output logic              key_went_up,
  output logic [8:0]        entry_key_code,
  output logic [3:0]        active_count
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [AW-1:0] AW_ONE    = AW'(1);

  logic [1:0]  cmd_r;
  logic [9:0]  key_r;
  logic [1:0]  act_r;
  logic [3:0]  idx_r;
  logic [AW-1:0] i, n, count, cnt_next;
  logic [AW:0]   i_p1;
  logic [AW+3:0] cnt_ext;
  entry_t      cur, rd_data, wr_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [ST_W-1:0] ev_st;
  logic        act_sets;

  pkt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign act_sets = (act_r == ACT_PRESS) || (act_r == ACT_RELEASE);
  assign ev_st    = (act_r == ACT_PRESS) ? ST_DOWN_FIRST : ST_UP_FIRST;
  assign i_p1     = {1'b0, i} + {{AW{1'b0}}, 1'b1};

  // read port
  assign rd_en = ctrl.rd_en;
  always_comb begin
    case (ctrl.rd_sel)
      RD_I:     rd_addr = i;
      RD_INEXT: rd_addr = i_p1[AW-1:0];
      RD_NLAST: rd_addr = n - AW_ONE;
      RD_INDEX: rd_addr = AW'(idx_r);
      default:  rd_addr = i;
    endcase
  end

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i;
    wr_data = rd_data;
    case (ctrl.wr_kind)
      WR_EVENT: begin
        wr_en      = act_sets;
        wr_data.st = ev_st;
      end
      WR_APPEND: begin
        wr_en        = 1'b1;
        wr_addr      = count;
        wr_data.code = key_r[CODE_W-1:0];
        wr_data.st   = act_sets ? ev_st : ST_UP;
      end
      WR_KEEP: begin
        wr_en      = 1'b1;
        wr_data    = cur;
        wr_data.st = ST_DOWN;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_next = count;
    if (ctrl.cnt_inc) cnt_next = count + AW_ONE;
    else if (ctrl.cnt_from_n) cnt_next = n;
  end
  assign cnt_ext = {4'b0, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      i     <= '0;
      n     <= '0;
      done  <= 1'b0;
    end else begin
      count <= cnt_next;
      done  <= (ctrl.res_kind != RES_NONE);
      if (ctrl.load_in) begin
        i <= '0;
        n <= count;
      end else begin
        if (ctrl.i_inc) i <= i_p1[AW-1:0];
        if (ctrl.n_dec) n <= n - AW_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= command;
      key_r <= key_code;
      act_r <= key_action;
      idx_r <= entry_index;
    end
    if (ctrl.cur_load) cur <= rd_data;
    if (ctrl.res_kind != RES_NONE) begin
      key_found      <= 1'b0;
      key_held       <= 1'b0;
      key_went_down  <= 1'b0;
      key_went_up    <= 1'b0;
      entry_key_code <= '0;
      active_count   <= cnt_ext[3:0];
      case (ctrl.res_kind)
        RES_FOUND: begin
          key_found     <= 1'b1;
          key_held      <= rd_data.st[1];
          key_went_down <= (rd_data.st == ST_DOWN_FIRST);
          key_went_up   <= (rd_data.st == ST_UP_FIRST);
        end
        RES_ENTRY: entry_key_code <= rd_data.code;
        default: ;
      endcase
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.negative  = key_r[9];
  assign stat.cnt_zero  = (count == '0);
  assign stat.append_ok = (count < LAST_SLOT);
  assign stat.idx_ok    = ((AW+4)'(idx_r) < (AW+4)'(count));
  assign stat.match     = (rd_data.code == key_r[CODE_W-1:0]);
  assign stat.last      = (i_p1 == {1'b0, count});
  assign stat.tick_done = (i >= n);
  assign stat.keep      = cur.st[1];
  assign stat.move_ok   = (i_p1 < {1'b0, n});

endmodule

>>> design/pressed_key_table_top.sv
// ----------------------------------------------------------------------------
// pressed_key_table_top
// Table of active keys with two-bit press state, frame aging and lookup.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears with done high for one cycle, and the next command may be taken in
// that same cycle. All entries sit in one RAM with one read port, so the
// time per command follows the table walk: a read by index reads the entry
// at that index (or ends at once when past the count), a key event or query
// searches the entries in order until a match or the last one, and a frame
// tick examines each entry, keeping it or removing it by moving the last
// entry into its place. Results must be taken as shown.
module pressed_key_table_top
  import pkt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic signed [9:0] key_code,
  input  logic [1:0]        key_action,
  input  logic [3:0]        entry_index,
  output logic              done,
  output logic              key_found,
  output logic              key_held,
  output logic              key_went_down,
  output logic              key_went_up,
  output logic [8:0]        entry_key_code,
  output logic [3:0]        active_count
);

  ctrl_t ctrl;
  stat_t stat;

  pkt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  pkt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .command        (command),
    .key_code       (key_code),
    .key_action     (key_action),
    .entry_index    (entry_index),
    .ctrl           (ctrl),
    .stat           (stat),
    .done           (done),
    .key_found      (key_found),
    .key_held       (key_held),
    .key_went_down  (key_went_down),
    .key_went_up    (key_went_up),
    .entry_key_code (entry_key_code),
    .active_count   (active_count)
  );

endmodule
